// ===== design/assert_macros.svh =====
// Assertion helpers for the design files; only sfsc_ctrl uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define SFSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfsc assertion failed");

// Check that a condition never holds outside of reset.
`define SFSC_NEVER(lbl, clk, rst_n, cond) \
  `SFSC_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== design/sfsc_pkg.sv =====
package sfsc_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] TYPE_ONE  = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_TWO  = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_THR  = 8'h03;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  // Fixed tap points of the byte chain seen by the controller.
  typedef struct packed {
    logic [BYTE_W-1:0] newest;  // cell 0
    logic [BYTE_W-1:0] second;  // cell 1
    logic [BYTE_W-1:0] oldest;  // last cell of the chain
  } chain_taps_t;

endpackage

// ===== design/sfsc_cell.sv =====
module sfsc_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [sfsc_pkg::BYTE_W-1:0] d_i,
  output logic [sfsc_pkg::BYTE_W-1:0] q_o
);
  import sfsc_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  // Take the neighbor's byte on a shift, hold otherwise.
  assign byte_d = shift_i ? d_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o = byte_q;

endmodule

// ===== design/sfsc_ctrl.sv =====
`include "assert_macros.svh"

module sfsc_ctrl #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sfsc_pkg::BYTE_W-1:0] in_byte_i,
  output logic                        in_ready_o,
  input  sfsc_pkg::chain_taps_t       taps_i,
  output logic                        shift_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sfsc_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        out_kind_o,
  output logic                        out_last_o
);
  import sfsc_pkg::*;

  localparam int unsigned FILL_W = $clog2(FRAME_LEN + 1);
  localparam int unsigned CNT_W  = $clog2(FRAME_LEN);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;

  logic              in_acc;
  logic              load_ok;
  logic [FILL_W-1:0] fill_inc;
  logic              hdr_ok;
  logic              drain_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_ok    = !out_vld_q || out_ready_i;
  assign fill_inc   = fill_q + FILL_W'(1);
  assign drain_last = (cnt_q == CNT_W'(FRAME_LEN - 1));

  // Header window before the append: sync pair in cells 1 and 0, type is the incoming word.
  assign hdr_ok = (taps_i.second == SYNC_BYTE) && (taps_i.newest == SYNC_BYTE) &&
                  ((in_byte_i == TYPE_ONE) || (in_byte_i == TYPE_TWO) ||
                   (in_byte_i == TYPE_THR));

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    shift_o    = 1'b0;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          shift_o = 1'b1;
          fill_d  = fill_inc;
          sum_d   = sum_q + in_byte_i;
          if (fill_inc == FILL_W'(3)) begin
            if (!hdr_ok) begin
              // drop the oldest word: it sits in cell 2 after the shift
              fill_d = FILL_W'(2);
              sum_d  = sum_q + in_byte_i - taps_i.second;
            end
          end else if (fill_inc == FILL_W'(FRAME_LEN)) begin
            fill_d = '0;
            sum_d  = '0;
            cnt_d  = '0;
            // checksum word must equal the sum of all earlier words
            state_d = (sum_q == in_byte_i) ? ST_DRAIN : ST_ERR;
          end
        end
      end
      ST_DRAIN: begin
        if (load_ok) begin
          shift_o    = 1'b1;
          out_vld_d  = 1'b1;
          out_byte_d = taps_i.oldest;
          out_kind_d = KIND_DATA;
          out_last_d = drain_last;
          cnt_d      = cnt_q + CNT_W'(1);
          if (drain_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (load_ok) begin
          out_vld_d  = 1'b1;
          out_byte_d = '0;
          out_kind_d = KIND_ERR;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  `SFSC_ASSERT(a_fill_below_len, clk_i, rst_ni, fill_q < FILL_W'(FRAME_LEN))
  `SFSC_ASSERT(a_empty_while_emit, clk_i, rst_ni, (state_q != ST_IDLE) |-> (fill_q == '0))
  `SFSC_ASSERT(a_err_shape, clk_i, rst_ni,
    (out_vld_q && (out_kind_q == KIND_ERR)) |-> (out_last_q && (out_byte_q == '0)))
  `SFSC_ASSERT(a_drain_ends_last, clk_i, rst_ni,
    (state_q == ST_DRAIN) ##1 (state_q == ST_IDLE) |-> (out_vld_q && out_last_q))

endmodule

// ===== design/serial_frame_sync_checksum_top.sv =====
// Channel   | Dir | Ports                          | Word contents (lowest bit up)
// ----------+-----+--------------------------------+-------------------------------------
// rx bytes  | in  | s_axis_tvalid/tready/tdata     | tdata: rx_byte[7:0]
// frames    | out | m_axis_tvalid/tready/tdata/    | tdata: frame_byte[7:0]
//           |     | tuser/tlast                    | tuser: kind, tlast: last
//
// A received word is taken whenever input is valid while hunting or collecting.
// A good frame then drains all FRAME_LEN words: the chain shifts one word a cycle
// while the output is not stalled, out of its oldest cell into the output register;
// a bad frame yields a single error word. Output stalls hold the drain; input is
// blocked while a frame result is sent.
// Reset (rst_ni low, async) empties the buffer and the output; no clearing pass.
module serial_frame_sync_checksum_top #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] frame_byte
  output logic       m_axis_tuser_o,   // [0] kind: data word or checksum error
  output logic       m_axis_tlast_o    // last word of a frame run
);
  import sfsc_pkg::*;

  logic [BYTE_W-1:0] cell_q [FRAME_LEN];
  logic              shift;
  chain_taps_t       taps;

  // Byte chain: new words enter cell 0, each cell takes its lower neighbor,
  // so the oldest buffered word always ends up nearest the top.
  for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
    logic [BYTE_W-1:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d = s_axis_tdata_i;
    end else begin : g_body
      assign cell_d = cell_q[k-1];
    end
    sfsc_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .d_i     (cell_d),
      .q_o     (cell_q[k])
    );
  end

  assign taps.newest = cell_q[0];
  assign taps.second = cell_q[1];
  assign taps.oldest = cell_q[FRAME_LEN-1];

  // Header hunt, fill and checksum tracking, drain sequencing, output register.
  sfsc_ctrl #(
    .FRAME_LEN (FRAME_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .taps_i      (taps),
    .shift_o     (shift),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
